>>> rtl/core/lcr_pkg.sv
// Shared types, widths, register indexes and the sequencer microcode for the line rasterizer.
package lcr_pkg;

  // Field widths
  localparam int unsigned CoordW   = 16;
  localparam int unsigned SpanW    = CoordW + 1;    // coordinate differences
  localparam int unsigned DenW     = CoordW;        // column span, 1..65535
  localparam int unsigned AccW     = 2 * SpanW;     // row numerator
  localparam int unsigned NumW     = AccW - 1;      // numerator magnitude
  localparam int unsigned QW       = SpanW + 1;     // floor quotient
  localparam int unsigned ColW     = 6;
  localparam int unsigned WidthW   = 7;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned DivCntW  = $clog2(NumW + 1);
  localparam int unsigned StepW    = 4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd1;

  localparam logic [WidthW-1:0]  WidthReset  = 7'd64;
  localparam logic [HeightW-1:0] HeightReset = 13'd64;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } lcr_in_t;

  typedef struct packed {
    logic [ColW-1:0]          column;
    logic signed [CoordW-1:0] row;
    logic                     row_visible;
    logic                     column_valid;
    logic                     last;
  } lcr_out_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } lcr_div_req_t;

  typedef struct packed {
    logic            busy;
    logic [NumW-1:0] quotient;
    logic [DenW-1:0] remainder;
  } lcr_div_rsp_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OpNop,
    OpSetup,
    OpMulA,
    OpMulB,
    OpAdd,
    OpDivN,
    OpDivD,
    OpFloorN,
    OpFloorD,
    OpEmit,
    OpStep,
    OpEmpty
  } lcr_op_e;

  // Sequencing conditions
  typedef enum logic [2:0] {
    CondNext,
    CondJump,
    CondInWait,
    CondDivWait,
    CondEmpty,
    CondOutLast,
    CondOutFree
  } lcr_cond_e;

  typedef struct packed {
    lcr_op_e          op;
    lcr_cond_e        cond;
    logic [StepW-1:0] target;
  } lcr_uword_t;

  // Microprogram addresses
  localparam logic [StepW-1:0] StepIdle   = 4'd0;
  localparam logic [StepW-1:0] StepSetup  = 4'd1;
  localparam logic [StepW-1:0] StepMulA   = 4'd2;
  localparam logic [StepW-1:0] StepMulB   = 4'd3;
  localparam logic [StepW-1:0] StepAdd    = 4'd4;
  localparam logic [StepW-1:0] StepDivN   = 4'd5;
  localparam logic [StepW-1:0] StepWaitN  = 4'd6;
  localparam logic [StepW-1:0] StepFloorN = 4'd7;
  localparam logic [StepW-1:0] StepDivD   = 4'd8;
  localparam logic [StepW-1:0] StepWaitD  = 4'd9;
  localparam logic [StepW-1:0] StepFloorD = 4'd10;
  localparam logic [StepW-1:0] StepEmit   = 4'd11;
  localparam logic [StepW-1:0] StepStep   = 4'd12;
  localparam logic [StepW-1:0] StepEmpty  = 4'd13;

  function automatic lcr_uword_t lcr_ucode(input logic [StepW-1:0] step);
    lcr_uword_t w;
    case (step)
      StepIdle:   w = '{op: OpNop,    cond: CondInWait,  target: StepIdle};
      StepSetup:  w = '{op: OpSetup,  cond: CondEmpty,   target: StepEmpty};
      StepMulA:   w = '{op: OpMulA,   cond: CondNext,    target: StepIdle};
      StepMulB:   w = '{op: OpMulB,   cond: CondNext,    target: StepIdle};
      StepAdd:    w = '{op: OpAdd,    cond: CondNext,    target: StepIdle};
      StepDivN:   w = '{op: OpDivN,   cond: CondNext,    target: StepIdle};
      StepWaitN:  w = '{op: OpNop,    cond: CondDivWait, target: StepIdle};
      StepFloorN: w = '{op: OpFloorN, cond: CondNext,    target: StepIdle};
      StepDivD:   w = '{op: OpDivD,   cond: CondNext,    target: StepIdle};
      StepWaitD:  w = '{op: OpNop,    cond: CondDivWait, target: StepIdle};
      StepFloorD: w = '{op: OpFloorD, cond: CondNext,    target: StepIdle};
      StepEmit:   w = '{op: OpEmit,   cond: CondOutLast, target: StepIdle};
      StepStep:   w = '{op: OpStep,   cond: CondJump,    target: StepEmit};
      StepEmpty:  w = '{op: OpEmpty,  cond: CondOutFree, target: StepIdle};
      default:    w = '{op: OpNop,    cond: CondJump,    target: StepIdle};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/lcr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lcr_div import lcr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lcr_div_req_t req_i,
  output lcr_div_rsp_t rsp_o
);

  logic [DivCntW-1:0] cnt_q;
  logic [NumW-1:0]    quo_q;
  logic [DenW-1:0]    rem_q;
  logic [DenW-1:0]    den_q;

  logic [DenW:0]   shifted;
  logic [DenW:0]   diff;
  logic            fits;
  logic [DenW-1:0] rem_next;

  always_comb begin
    shifted  = {rem_q, quo_q[NumW-1]};
    diff     = shifted - {1'b0, den_q};
    fits     = shifted >= {1'b0, den_q};
    rem_next = fits ? diff[DenW-1:0] : shifted[DenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= DivCntW'(NumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= rem_next;
    end
  end

  assign rsp_o.busy      = cnt_q != '0;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/core/line_column_rasterizer_top.sv
// Line column rasterizer: top level with microcoded sequencer and datapath.
//
// Use:
//   in_valid_i/in_stall_o/in_item_i carry one line request (two endpoints).
//   out_valid_o/out_stall_i/out_item_o carry one item per column of the line
//   that falls inside the image width, left to right, with the rounded row,
//   a visibility flag and a last marker. A request with no such column gives
//   a single empty item (column_valid 0, last 1).
//   cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i write image_width (0) and
//   image_height (1); write only while the block is idle. cfg_ready_o is
//   always high; other indexes are dropped.
// Sequence:
//   A request runs through a 14-step microprogram: setup steps (setup,
//   multiply A, multiply B, add), two 33-bit divisions on the shared
//   restoring divider (numerator of the first column, then the slope), each
//   with a wait step and a floor step, then two steps per column (emit,
//   step), the last column ending at its emit. An empty request goes from
//   setup straight to the empty step. Most of a request's time is divider waits.
// Reset: sequencer returns to idle, output empties, width and height are 64.
// Stall: the output register holds its item; the sequencer waits at the emit
//   or empty step. The next request is accepted once the last item sits in
//   the output register, even if it has not been taken yet.
module line_column_rasterizer_top import lcr_pkg::*; #(
  parameter int unsigned MaxWidth = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcr_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcr_out_t            out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------- control state ----------------
  logic [StepW-1:0]   step_q, step_d;
  logic               out_valid_q;
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;

  // ---------------- datapath registers ----------------
  lcr_in_t                  in_q;
  logic [DenW-1:0]          den_q;   // column span, 1 for a vertical line
  logic signed [SpanW-1:0]  dy_q;
  logic signed [AccW-1:0]   acc_q;   // row numerator at the first column
  logic signed [AccW-1:0]   mul_q;
  logic                     neg_q;   // sign of the value being divided
  logic signed [QW-1:0]     q_q;     // floor(row numerator / span)
  logic [DenW-1:0]          r_q;     // its remainder
  logic signed [QW-1:0]     qd_q;    // floor(dy / span)
  logic [DenW-1:0]          rd_q;
  logic [ColW-1:0]          cur_q;
  logic [ColW-1:0]          hi_q;
  lcr_out_t                 out_q;

  lcr_uword_t   uw;
  lcr_div_req_t div_req;
  lcr_div_rsp_t div_rsp;

  logic in_fire, out_free, is_last;

  assign uw         = lcr_ucode(step_q);
  assign in_stall_o = uw.cond != CondInWait;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_last    = cur_q == hi_q;

  // ---------------- setup arithmetic ----------------
  logic signed [SpanW-1:0] span;
  logic signed [SpanW-1:0] dy;
  logic [CoordW-1:0]       lo;
  logic [WidthW-1:0]       w_eff;
  logic signed [SpanW-1:0] wm1;
  logic signed [SpanW-1:0] hi;
  logic                    empty;

  always_comb begin
    span  = SpanW'(in_q.end_x) - SpanW'(in_q.start_x);
    dy    = SpanW'(in_q.end_y) - SpanW'(in_q.start_y);
    lo    = in_q.start_x[CoordW-1] ? '0 : in_q.start_x;
    w_eff = (width_q > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : width_q;
    wm1   = $signed({{(SpanW-WidthW){1'b0}}, w_eff}) - SpanW'(1);
    hi    = (SpanW'(in_q.end_x) < wm1) ? SpanW'(in_q.end_x) : wm1;
    empty = $signed({1'b0, lo}) > hi;
  end

  // ---------------- shared multiplier ----------------
  logic signed [SpanW-1:0] mul_a, mul_b;
  logic signed [AccW-1:0]  prod;
  logic signed [SpanW-1:0] offset;

  always_comb begin
    offset = $signed({{(SpanW-ColW){1'b0}}, cur_q}) - SpanW'(in_q.start_x);
    if (uw.op == OpMulA) begin
      mul_a = SpanW'(in_q.start_y);
      mul_b = $signed({1'b0, den_q});
    end else begin
      mul_a = dy_q;
      mul_b = offset;
    end
    prod = AccW'(mul_a) * AccW'(mul_b);
  end

  // ---------------- divider request and floor conversion ----------------
  logic [AccW-1:0]  acc_mag;
  logic [SpanW-1:0] dy_mag;
  logic [QW-1:0]    mq;
  logic signed [QW-1:0] fq;
  logic [DenW-1:0]  fr;

  always_comb begin
    acc_mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
    dy_mag  = dy_q[SpanW-1] ? SpanW'(-dy_q) : SpanW'(dy_q);

    div_req.start    = uw.op == OpDivN || uw.op == OpDivD;
    div_req.dividend = (uw.op == OpDivN) ? acc_mag[NumW-1:0]
                                         : {{(NumW-SpanW){1'b0}}, dy_mag};
    div_req.divisor  = den_q;

    // turn magnitude division into floor division
    mq = div_rsp.quotient[QW-1:0];
    if (neg_q && div_rsp.remainder != '0) begin
      fq = $signed(~mq);
      fr = den_q - div_rsp.remainder;
    end else if (neg_q) begin
      fq = $signed(-mq);
      fr = '0;
    end else begin
      fq = $signed(mq);
      fr = div_rsp.remainder;
    end
  end

  lcr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- rounding, stepping ----------------
  logic [DenW:0]        r2;
  logic                 round_up;
  logic signed [QW-1:0] row;
  logic                 visible;
  logic [DenW:0]        rsum;
  logic                 wrap;
  logic [DenW:0]        rwrap;

  always_comb begin
    // half away from zero: negative values round up only past the half
    r2       = {r_q, 1'b0};
    round_up = q_q[QW-1] ? (r2 > {1'b0, den_q}) : (r2 >= {1'b0, den_q});
    row      = q_q + QW'(round_up);
    visible  = !row[QW-1] && (row < $signed({{(QW-HeightW){1'b0}}, height_q}));

    rsum  = {1'b0, r_q} + {1'b0, rd_q};
    wrap  = rsum >= {1'b0, den_q};
    rwrap = rsum - {1'b0, den_q};
  end

  // ---------------- sequencer ----------------
  always_comb begin
    case (uw.cond)
      CondNext:    step_d = step_q + 1'b1;
      CondJump:    step_d = uw.target;
      CondInWait:  step_d = in_fire ? step_q + 1'b1 : step_q;
      CondDivWait: step_d = div_rsp.busy ? step_q : step_q + 1'b1;
      CondEmpty:   step_d = empty ? uw.target : step_q + 1'b1;
      CondOutLast: step_d = !out_free ? step_q : (is_last ? uw.target : step_q + 1'b1);
      CondOutFree: step_d = out_free ? uw.target : step_q;
      default:     step_d = StepIdle;
    endcase
  end

  logic out_load;
  assign out_load = out_free && (uw.op == OpEmit || uw.op == OpEmpty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepIdle;
      out_valid_q <= 1'b0;
      width_q     <= WidthReset;
      height_q    <= HeightReset;
    end else begin
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgWidth:  width_q  <= cfg_data_i[WidthW-1:0];
          CfgHeight: height_q <= cfg_data_i[HeightW-1:0];
          default:   ;
        endcase
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_item_i;
    end
    case (uw.op)
      OpSetup: begin
        den_q <= (span == '0) ? DenW'(1) : span[DenW-1:0];
        dy_q  <= dy;
        cur_q <= lo[ColW-1:0];
        hi_q  <= hi[ColW-1:0];
      end
      OpMulA: mul_q <= prod;
      OpMulB: begin
        acc_q <= mul_q;
        mul_q <= prod;
      end
      OpAdd:  acc_q <= acc_q + mul_q;
      OpDivN: neg_q <= acc_q[AccW-1];
      OpDivD: neg_q <= dy_q[SpanW-1];
      OpFloorN: begin
        q_q <= fq;
        r_q <= fr;
      end
      OpFloorD: begin
        qd_q <= fq;
        rd_q <= fr;
      end
      OpEmit: begin
        if (out_free) begin
          out_q.column       <= cur_q;
          out_q.row          <= row[CoordW-1:0];
          out_q.row_visible  <= visible;
          out_q.column_valid <= 1'b1;
          out_q.last         <= is_last;
        end
      end
      OpStep: begin
        cur_q <= cur_q + 1'b1;
        r_q   <= wrap ? rwrap[DenW-1:0] : rsum[DenW-1:0];
        q_q   <= q_q + qd_q + QW'(wrap);
      end
      OpEmpty: begin
        if (out_free) begin
          out_q <= '{column: '0, row: '0, row_visible: 1'b0, column_valid: 1'b0,
                     last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // ---------------- assertions ----------------
  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == StepEmit) |-> (r_q < den_q))
    else $error("row remainder not below column span");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == StepEmit || step_q == StepStep) |-> (cur_q <= hi_q))
    else $error("column ran past last column");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_floor_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == StepFloorN || step_q == StepFloorD) |-> !div_rsp.busy)
    else $error("quotient read before division finished");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled output item overwritten");

endmodule
